>>> sv/guest_region_translation_table_core_assert.svh
// Assertion macros used by the guest region translation table controller (grtt_ctl).
`ifndef GUEST_REGION_TRANSLATION_TABLE_CORE_ASSERT_SVH
`define GUEST_REGION_TRANSLATION_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define GRTT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("grtt assertion failed");
`define GRTT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("grtt assertion failed");
`else
`define GRTT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define GRTT_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> sv/grtt_pkg.sv
// Shared types, constants and field layout of the guest region translation table.
`default_nettype none
package grtt_pkg;

    localparam int REGION_ENTRIES  = 16;
    localparam int GUEST_ADDR_BITS = 48;

    localparam int GUEST_FIELD_W = 48;
    localparam int HOST_W        = 64;
    localparam int SIZE_FIELD_W  = 49;
    localparam int RIGHTS_W      = 3;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;

    localparam int GA_W  = (GUEST_ADDR_BITS < GUEST_FIELD_W) ? GUEST_ADDR_BITS : GUEST_FIELD_W;
    localparam int LEN_W = GA_W + 1;
    localparam int END_W = GA_W + 2;
    localparam int IDX_W = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;

    localparam int HOST_LSB   = GUEST_FIELD_W;
    localparam int SIZE_LSB   = HOST_LSB + HOST_W;
    localparam int RIGHTS_LSB = SIZE_LSB + SIZE_FIELD_W;
    localparam int S_FIELDS_W = RIGHTS_LSB + RIGHTS_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = HOST_W + RIGHTS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_COLLIDE = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_DRAIN,
        CS_DONE
    } ctl_state_t;

    typedef struct packed {
        logic [RIGHTS_W-1:0] rights;
        logic [LEN_W-1:0]    length;
        logic [HOST_W-1:0]   host_base;
        logic [GA_W-1:0]     guest_base;
    } entry_t;

    typedef struct packed {
        logic             capture;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

>>> sv/grtt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module grtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> sv/grtt_ctl.sv
// Controller state machine that sequences capture, table scan and result commit.
`default_nettype none
`include "guest_region_translation_table_core_assert.svh"
module grtt_ctl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire grtt_pkg::dp_stat_t  stat,
    output grtt_pkg::ctl_cmd_t       cmd
);
    import grtt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGION_ENTRIES - 1);

    ctl_state_t       state_reg;
    ctl_state_t       state_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            CS_IDLE: begin
                cnt_next = '0;
                if (s_tvalid) begin
                    state_next = CS_SCAN;
                end
            end
            CS_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    cnt_next   = '0;
                    state_next = CS_DRAIN;
                end
            end
            CS_DRAIN: begin
                state_next = CS_DONE;
            end
            CS_DONE: begin
                if (stat.out_free) begin
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.rd_addr = cnt_reg;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            CS_SCAN: begin
                cmd.rd_en = 1'b1;
            end
            CS_DRAIN: begin
            end
            CS_DONE: begin
                cmd.commit = stat.out_free;
            end
            default: begin
            end
        endcase
    end

    `GRTT_ASSERT_NXT(a_capture_starts_scan, aclk, aresetn, cmd.capture, (state_reg == CS_SCAN) && (cnt_reg == '0))
    `GRTT_ASSERT_IMP(a_commit_needs_room, aclk, aresetn, cmd.commit, stat.out_free)
    `GRTT_ASSERT_NXT(a_scan_ends_in_drain, aclk, aresetn, (state_reg == CS_SCAN) && (cnt_reg == LAST_IDX), state_reg == CS_DRAIN)

endmodule
`default_nettype wire

>>> sv/grtt_dp.sv
// Datapath: item capture, entry memory, valid bits, per-entry tests and result register.
`default_nettype none
module grtt_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire grtt_pkg::ctl_cmd_t                cmd,
    output grtt_pkg::dp_stat_t                     stat,
    input  wire logic [grtt_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [grtt_pkg::OP_W-1:0]         s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [grtt_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic      [grtt_pkg::STATUS_W-1:0]     m_tuser
);
    import grtt_pkg::*;

    op_t                  op_reg;
    logic [GA_W-1:0]      ga_reg;
    logic [HOST_W-1:0]    ha_reg;
    logic [LEN_W-1:0]     sz_reg;
    logic [RIGHTS_W-1:0]  rt_reg;
    logic [END_W-1:0]     nend_reg;

    logic [REGION_ENTRIES-1:0] valid_reg;
    logic                      eval_en_reg;
    logic [IDX_W-1:0]          eval_idx_reg;

    logic                 coll_reg;
    logic                 match_reg;
    logic [IDX_W-1:0]     match_idx_reg;
    logic [HOST_W-1:0]    hit_host_reg;
    logic [GA_W-1:0]      hit_off_reg;
    logic [RIGHTS_W-1:0]  hit_rights_reg;

    logic                 m_tvalid_reg;
    status_t              out_status_reg;
    logic [HOST_W-1:0]    out_xlat_reg;
    logic [RIGHTS_W-1:0]  out_rights_reg;

    logic [$bits(entry_t)-1:0] rd_word;
    entry_t               ent;
    entry_t               new_ent;
    logic                 ent_live;
    logic [END_W-1:0]     base_w;
    logic [END_W-1:0]     ent_end;
    logic [END_W-1:0]     a_w;
    logic                 t_in;
    logic                 t_tail;
    logic                 t_cover;
    logic                 exact;
    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;
    logic                 add_ok;

    logic [GA_W-1:0]      ga_in;
    logic [LEN_W-1:0]     sz_in;

    assign ga_in = s_tdata[GA_W-1:0];
    assign sz_in = s_tdata[SIZE_LSB +: LEN_W];

    assign new_ent.guest_base = ga_reg;
    assign new_ent.host_base  = ha_reg;
    assign new_ent.length     = sz_reg;
    assign new_ent.rights     = rt_reg;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = REGION_ENTRIES - 1; k >= 0; k--) begin
            if (!valid_reg[k]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(k);
            end
        end
    end

    assign add_ok = cmd.commit && (op_reg == OP_ADD) && !coll_reg && free_found;

    grtt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (REGION_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (add_ok),
        .wr_addr (free_idx),
        .wr_data (new_ent),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_word)
    );

    always_comb begin
        ent      = entry_t'(rd_word);
        ent_live = eval_en_reg && valid_reg[eval_idx_reg];
        base_w   = END_W'(ent.guest_base);
        ent_end  = base_w + END_W'(ent.length);
        a_w      = END_W'(ga_reg);
        t_in     = (a_w >= base_w) && (a_w < ent_end);
        t_tail   = (nend_reg > base_w) && (nend_reg <= ent_end);
        t_cover  = (a_w <= base_w) && (nend_reg >= ent_end);
        exact    = (ent.host_base == ha_reg) && (ent.guest_base == ga_reg) &&
                   (ent.length == sz_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= op_t'(s_tuser);
            ga_reg   <= ga_in;
            ha_reg   <= s_tdata[HOST_LSB +: HOST_W];
            sz_reg   <= sz_in;
            rt_reg   <= s_tdata[RIGHTS_LSB +: RIGHTS_W];
            nend_reg <= END_W'(ga_in) + END_W'(sz_in);
        end
        eval_idx_reg <= cmd.rd_addr;
        if (ent_live && (op_reg == OP_LOOKUP) && t_in) begin
            hit_host_reg   <= ent.host_base;
            hit_off_reg    <= ga_reg - ent.guest_base;
            hit_rights_reg <= ent.rights;
        end
        if (ent_live && (op_reg == OP_DELETE) && exact) begin
            match_idx_reg <= eval_idx_reg;
        end
        if (cmd.commit) begin
            if ((op_reg == OP_LOOKUP) && match_reg) begin
                out_xlat_reg   <= hit_host_reg + HOST_W'(hit_off_reg);
                out_rights_reg <= hit_rights_reg;
            end else begin
                out_xlat_reg   <= '0;
                out_rights_reg <= '0;
            end
            unique case (op_reg)
                OP_ADD: begin
                    if (coll_reg) begin
                        out_status_reg <= ST_COLLIDE;
                    end else if (!free_found) begin
                        out_status_reg <= ST_FULL;
                    end else begin
                        out_status_reg <= ST_OK;
                    end
                end
                OP_DELETE: begin
                    out_status_reg <= match_reg ? ST_OK : ST_MISSING;
                end
                OP_LOOKUP: begin
                    out_status_reg <= match_reg ? ST_OK : ST_MISSING;
                end
                OP_CLEAR: begin
                    out_status_reg <= ST_OK;
                end
                default: begin
                    out_status_reg <= ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            eval_en_reg  <= 1'b0;
            coll_reg     <= 1'b0;
            match_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            eval_en_reg <= cmd.rd_en;
            if (cmd.capture) begin
                coll_reg  <= 1'b0;
                match_reg <= 1'b0;
            end else if (ent_live) begin
                priority case (op_reg)
                    OP_ADD: begin
                        if (t_in || t_tail || t_cover) begin
                            coll_reg <= 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (exact) begin
                            match_reg <= 1'b1;
                        end
                    end
                    OP_LOOKUP: begin
                        if (t_in) begin
                            match_reg <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.commit) begin
                if (add_ok) begin
                    valid_reg[free_idx] <= 1'b1;
                end
                if ((op_reg == OP_DELETE) && match_reg) begin
                    valid_reg[match_idx_reg] <= 1'b0;
                end
                if (op_reg == OP_CLEAR) begin
                    valid_reg <= '0;
                end
            end
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_rights_reg, out_xlat_reg};

endmodule
`default_nettype wire

>>> sv/guest_region_translation_table_core.sv
// Top level of the guest region translation table: controller and datapath.
// Items are handled one at a time: accept, a scan of all 16 entries through the single
// read port of the entry memory, a drain step and a commit that waits for output room.
// The next input beat is accepted while an earlier result still waits in the output register.
// Reset (aresetn, synchronous, active low) empties the table at once and idles the block.
`default_nettype none
module guest_region_translation_table_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: guest_addr[47:0], host_addr[111:48], region_size[160:112], rights[163:161].
    input  wire logic [grtt_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: operation[1:0].
    input  wire logic [grtt_pkg::OP_W-1:0]         s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: translated_addr[63:0], found_rights[66:64].
    output logic      [grtt_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: status[1:0].
    output logic      [grtt_pkg::STATUS_W-1:0]     m_tuser
);
    import grtt_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    grtt_ctl u_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    grtt_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire
